// ===== design/error_diffusion_dither_assert.svh =====
// Assertion macros for the error diffusion dither block.
// Define NO_ASSERTIONS to compile them out.
`ifndef ERROR_DIFFUSION_DITHER_ASSERT_SVH
`define ERROR_DIFFUSION_DITHER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define EDD_ASSERT(label, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("edd: invariant violated");
`define EDD_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("edd: sequence violated");
`else
`define EDD_ASSERT(label, cond)
`define EDD_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== design/edd_pkg.sv =====
package edd_pkg;

   localparam int MAX_WIDTH_DEF = 4096;
   localparam int PIX_W         = 8;
   localparam int ACC_W         = 10;
   localparam int BPP_W         = 4;
   localparam int IW_W          = 13;
   localparam int IH_W          = 16;
   localparam int CSR_W         = 16;
   localparam int CSR_IDX_W     = 2;

   localparam int ACC_MAXV = 2 ** (ACC_W - 1) - 1;
   localparam int ACC_MINV = -(2 ** (ACC_W - 1));

   typedef enum logic [1:0] {
      KERN_FS       = 2'd0,
      KERN_JJN      = 2'd1,
      KERN_SIERRA   = 2'd2,
      KERN_ATKINSON = 2'd3
   } kern_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_KERNEL = 2'd0,
      REG_BPP    = 2'd1,
      REG_WIDTH  = 2'd2,
      REG_HEIGHT = 2'd3
   } csr_idx_type;

   typedef logic signed [ACC_W-1:0] acc_type;
   typedef logic signed [ACC_W:0]   acc_ext_type;

   // weights indexed [row offset][column offset + 2]
   localparam logic [2:0] W_FS [0:2][0:4] = '{
      '{3'd0, 3'd0, 3'd0, 3'd7, 3'd0},
      '{3'd0, 3'd3, 3'd5, 3'd1, 3'd0},
      '{3'd0, 3'd0, 3'd0, 3'd0, 3'd0}};
   localparam logic [2:0] W_JJN [0:2][0:4] = '{
      '{3'd0, 3'd0, 3'd0, 3'd7, 3'd5},
      '{3'd3, 3'd5, 3'd7, 3'd5, 3'd3},
      '{3'd1, 3'd3, 3'd5, 3'd3, 3'd1}};
   localparam logic [2:0] W_SIERRA [0:2][0:4] = '{
      '{3'd0, 3'd0, 3'd0, 3'd5, 3'd3},
      '{3'd2, 3'd4, 3'd5, 3'd4, 3'd2},
      '{3'd0, 3'd2, 3'd3, 3'd2, 3'd0}};
   localparam logic [2:0] W_ATK [0:2][0:4] = '{
      '{3'd0, 3'd0, 3'd0, 3'd1, 3'd1},
      '{3'd0, 3'd1, 3'd1, 3'd1, 3'd0},
      '{3'd0, 3'd0, 3'd1, 3'd0, 3'd0}};

   function automatic logic [2:0] tap_weight(kern_type k, int dr, int kk);
      logic [2:0] wt;
      case (k)
         KERN_FS: begin
            wt = W_FS[dr][kk];
         end
         KERN_JJN: begin
            wt = W_JJN[dr][kk];
         end
         KERN_SIERRA: begin
            wt = W_SIERRA[dr][kk];
         end
         KERN_ATKINSON: begin
            wt = W_ATK[dr][kk];
         end
         default: begin
            wt = 3'd0;
         end
      endcase
      return wt;
   endfunction

   // err * wt / divisor, truncated toward zero
   function automatic acc_type share(kern_type k, logic signed [8:0] err, logic [2:0] wt);
      logic [7:0]  mag;
      logic [10:0] prod;
      logic [6:0]  y;
      logic [14:0] t;
      logic [7:0]  qv;
      acc_type     sv;
      mag  = err[8] ? 8'(-err) : 8'(err);
      prod = {3'b0, mag} * {8'b0, wt};
      y    = 7'(prod >> 4);
      t    = {8'b0, y} * 15'd171;
      case (k)
         KERN_FS: begin
            qv = 8'(prod >> 4);
         end
         KERN_JJN: begin
            qv = 8'(t >> 9);   // (prod/16)/3
         end
         KERN_SIERRA: begin
            qv = 8'(prod >> 5);
         end
         KERN_ATKINSON: begin
            qv = 8'(prod >> 3);
         end
         default: begin
            qv = 8'd0;
         end
      endcase
      sv = acc_type'({2'b0, qv});
      return err[8] ? -sv : sv;
   endfunction

   function automatic acc_type sat_acc(acc_ext_type v);
      acc_type r;
      if (v > acc_ext_type'(ACC_MAXV)) begin
         r = acc_type'(ACC_MAXV);
      end else if (v < acc_ext_type'(ACC_MINV)) begin
         r = acc_type'(ACC_MINV);
      end else begin
         r = v[ACC_W-1:0];
      end
      return r;
   endfunction

   function automatic logic [PIX_W-1:0] quantize(logic [PIX_W-1:0] p, logic [BPP_W-1:0] bits);
      logic [PIX_W-1:0] r;
      case (bits)
         4'd1: begin
            r = {8{p[7]}};
         end
         4'd2: begin
            r = {p[7:6], p[7:6], p[7:6], p[7:6]};
         end
         4'd3: begin
            r = {p[7:5], p[7:5], p[7:6]};
         end
         default: begin
            r = p & (8'hFF << (4'd8 - bits));
         end
      endcase
      return r;
   endfunction

endpackage

// ===== design/error_diffusion_dither.sv =====
// Error diffusion dither, one 8-bit grey pixel in, one quantized pixel out.
// req_*: pixels in raster order, one per item. rsp_*: quantized pixel per
// item, rsp_tlast high on the last pixel of a frame. csr_*: write-only
// registers (kernel, depth, width, height), to be written only while idle;
// the block does not enforce this. Pixels are registered for read/compute,
// then in the output queue. Throughput: one pixel per cycle unless stalled;
// two RAMs (next-row and row-after-next) hold the error rows, read at
// acceptance and written two columns behind, so each sees one read and one
// write per pixel. A four-column register window holds error to next rows.
// The two trailing columns of a row are written back in free write slots
// at the start of the next row through a short queue, with forwarding.
// A three-entry output queue absorbs stalls; req_tready drops only when it
// and the compute stage together hold three items, so a stalled receiver
// stops input after at most three pending items and nothing is lost.
// Reset: registers go to their defaults, counters to the frame origin; the
// RAMs need no clearing, since a fill mark (last column of the previous row)
// and the row number decide which entries are valid.
`include "error_diffusion_dither_assert.svh"
module error_diffusion_dither import edd_pkg::*; #(
   parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [7:0]           req_tdata,   // [7:0] pixel_in
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [7:0]           rsp_tdata,   // [7:0] pixel_out
   output logic                 rsp_tlast,   // frame_end
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   localparam int CW  = $clog2(MAX_WIDTH);
   localparam int WW  = CW + 1;
   localparam int QD  = 4;
   localparam int QCW = $clog2(QD + 1);
   localparam int OD  = 3;

   // ---------------- configuration ----------------
   kern_type          kern_ff;
   logic [BPP_W-1:0]  bpp_ff;
   logic [IW_W-1:0]   iw_ff;
   logic [IH_W-1:0]   ih_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         kern_ff <= KERN_FS;
         bpp_ff  <= 4'd1;
         iw_ff   <= 13'd640;
         ih_ff   <= 16'd480;
      end else if (csr_we) begin
         case (csr_idx_type'(csr_index))
            REG_KERNEL: begin
               kern_ff <= kern_type'(csr_wdata[1:0]);
            end
            REG_BPP: begin
               bpp_ff <= csr_wdata[BPP_W-1:0];
            end
            REG_WIDTH: begin
               iw_ff <= csr_wdata[IW_W-1:0];
            end
            REG_HEIGHT: begin
               ih_ff <= csr_wdata[IH_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   logic [WW-1:0]     w_eff;
   logic [IH_W:0]     h_eff;
   logic [BPP_W-1:0]  bits_eff;

   assign w_eff = (iw_ff == '0) ? WW'(1) :
                  ((32'(iw_ff) > 32'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(iw_ff));
   assign h_eff = (ih_ff == '0) ? (IH_W+1)'(1) : (IH_W+1)'(ih_ff);
   assign bits_eff = (bpp_ff == '0) ? 4'd1 : ((bpp_ff > 4'd8) ? 4'd8 : bpp_ff);

   // ---------------- accept stage ----------------
   logic [CW-1:0]   col_ff;
   logic [IH_W-1:0] row_ff;
   logic [CW-1:0]   last_col_ff;   // last column written by the previous row
   logic            acc;
   logic            row_end_a, frame_end_a;
   logic [WW-1:0]   ra2;

   assign acc         = req_tvalid && req_tready;
   assign row_end_a   = {1'b0, col_ff} >= (w_eff - WW'(1));
   assign frame_end_a = row_end_a && ((IH_W+1)'(row_ff) >= (h_eff - (IH_W+1)'(1)));
   assign ra2         = {1'b0, col_ff} + WW'(2);

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         last_col_ff <= '0;
      end else if (acc) begin
         if (row_end_a) begin
            col_ff      <= '0;
            last_col_ff <= col_ff;
            row_ff      <= frame_end_a ? '0 : row_ff + 16'd1;
         end else begin
            col_ff <= col_ff + CW'(1);
         end
      end
   end

   // ---------------- compute stage registers ----------------
   logic             s1_v_ff;
   logic [7:0]       s1_pix_ff;
   logic [CW-1:0]    s1_col_ff;
   logic [IH_W-1:0]  s1_row_ff;
   logic             s1_rend_ff, s1_fend_ff;
   logic             s1_cur_ok_ff, s1_seed_ok_ff, s1_hv0_ff, s1_hv1_ff;
   logic             s1_f1_hit_ff, s1_f2_hit_ff;
   acc_type          s1_f1_val_ff, s1_f2_val_ff;

   // window: columns col-1 .. col+2 after the last pixel, next row and row after
   acc_type w1_ff [4];
   acc_type w2_ff [4];
   acc_type a0_ff, a1_ff;
   acc_type head_ff [2];   // row-after-next error of columns 0 and 1

   // write-back queue for trailing columns of a row
   logic [CW-1:0] qa_ff [QD];
   acc_type       q1_ff [QD];
   acc_type       q2_ff [QD];
   logic [QCW-1:0] qcnt_ff;

   acc_type m1_q, m2_q;

   // ---------------- compute ----------------
   acc_type          cur, seed;
   logic signed [11:0] sum;
   logic [7:0]       clamp_px, qpx;
   logic signed [8:0] err;
   acc_type          wb1 [5];
   acc_type          wb2 [5];
   acc_type          w1n [5];
   acc_type          w2n [5];
   acc_type          a0n, a1n;
   int               c_i, w_i;
   logic             row1_ok, row2_ok;
   logic [2:0]       wt;

   always_comb begin
      c_i  = int'(s1_col_ff);
      w_i  = int'(w_eff);
      cur  = s1_cur_ok_ff ? (s1_f1_hit_ff ? s1_f1_val_ff : m1_q) : '0;
      seed = s1_seed_ok_ff ? (s1_f2_hit_ff ? s1_f2_val_ff : m2_q) : '0;
      sum  = $signed({4'b0, s1_pix_ff}) + 12'(cur) + 12'(a0_ff);
      if (sum < 0) begin
         clamp_px = 8'd0;
      end else if (sum > 12'sd255) begin
         clamp_px = 8'd255;
      end else begin
         clamp_px = sum[7:0];
      end
      qpx = quantize(clamp_px, bits_eff);
      err = $signed({1'b0, clamp_px}) - $signed({1'b0, qpx});

      if (s1_col_ff == '0) begin
         wb1[0] = '0;
         wb1[1] = '0;
         wb1[2] = s1_hv0_ff ? head_ff[0] : '0;
         wb1[3] = s1_hv1_ff ? head_ff[1] : '0;
         for (int k = 0; k < 4; k++) begin
            wb2[k] = '0;
         end
      end else begin
         for (int k = 0; k < 4; k++) begin
            wb1[k] = w1_ff[k];
            wb2[k] = w2_ff[k];
         end
      end
      wb1[4] = seed;
      wb2[4] = '0;

      row1_ok = (int'(s1_row_ff) + 1) < int'(h_eff);
      row2_ok = (int'(s1_row_ff) + 2) < int'(h_eff);
      for (int k = 0; k < 5; k++) begin
         w1n[k] = wb1[k];
         w2n[k] = wb2[k];
         if ((c_i + k >= 2) && (c_i + k - 2 < w_i)) begin
            if (row1_ok) begin
               wt = tap_weight(kern_ff, 1, k);
               w1n[k] = sat_acc(acc_ext_type'(wb1[k]) +
                                acc_ext_type'(share(kern_ff, err, wt)));
            end
            if (row2_ok) begin
               wt = tap_weight(kern_ff, 2, k);
               w2n[k] = sat_acc(acc_ext_type'(wb2[k]) +
                                acc_ext_type'(share(kern_ff, err, wt)));
            end
         end
      end
      wt = tap_weight(kern_ff, 0, 3);
      a0n = (c_i + 1 < w_i) ?
            sat_acc(acc_ext_type'(a1_ff) + acc_ext_type'(share(kern_ff, err, wt))) : a1_ff;
      wt = tap_weight(kern_ff, 0, 4);
      a1n = (c_i + 2 < w_i) ? share(kern_ff, err, wt) : '0;
   end

   // final columns leaving the window: col-2 once col >= 2, col-1 and col at row end
   logic          fin_v [3];
   logic [CW-1:0] fin_a [3];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         fin_a[k] = s1_col_ff - CW'(2 - k);
      end
      fin_v[0] = s1_v_ff && (s1_col_ff >= CW'(2));
      fin_v[1] = s1_v_ff && s1_rend_ff && (s1_col_ff >= CW'(1));
      fin_v[2] = s1_v_ff && s1_rend_ff;
   end

   // ---------------- RAM write port and queue ----------------
   logic          drain;
   logic          mw_en;
   logic [CW-1:0] mw_addr;
   acc_type       mw_d1, mw_d2;

   assign drain   = (qcnt_ff != '0) && !fin_v[0];
   assign mw_en   = fin_v[0] || drain;
   assign mw_addr = fin_v[0] ? fin_a[0] : qa_ff[0];
   assign mw_d1   = fin_v[0] ? w1n[0] : q1_ff[0];
   assign mw_d2   = fin_v[0] ? w2n[0] : q2_ff[0];

   logic [CW-1:0]  nqa [QD];
   acc_type        nq1 [QD];
   acc_type        nq2 [QD];
   logic [QCW-1:0] nqcnt;

   always_comb begin
      for (int i = 0; i < QD; i++) begin
         nqa[i] = qa_ff[i];
         nq1[i] = q1_ff[i];
         nq2[i] = q2_ff[i];
      end
      nqcnt = qcnt_ff;
      if (drain) begin
         for (int i = 0; i < QD - 1; i++) begin
            nqa[i] = qa_ff[i+1];
            nq1[i] = q1_ff[i+1];
            nq2[i] = q2_ff[i+1];
         end
         nqcnt = qcnt_ff - QCW'(1);
      end
      for (int k = 1; k < 3; k++) begin
         if (fin_v[k] && (nqcnt < QCW'(QD))) begin
            nqa[nqcnt[QCW-2:0]] = fin_a[k];
            nq1[nqcnt[QCW-2:0]] = w1n[k];
            nq2[nqcnt[QCW-2:0]] = w2n[k];
            nqcnt = nqcnt + QCW'(1);
         end
      end
   end

   // ---------------- read forwarding ----------------
   logic    f1_hit, f2_hit;
   acc_type f1_val, f2_val;

   always_comb begin
      f1_hit = 1'b0;
      f2_hit = 1'b0;
      f1_val = '0;
      f2_val = '0;
      for (int i = 0; i < QD; i++) begin
         if (QCW'(i) < qcnt_ff) begin
            if (qa_ff[i] == col_ff) begin
               f1_hit = 1'b1;
               f1_val = q1_ff[i];
            end
            if ({1'b0, qa_ff[i]} == ra2) begin
               f2_hit = 1'b1;
               f2_val = q2_ff[i];
            end
         end
      end
      for (int k = 0; k < 3; k++) begin
         if (fin_v[k]) begin
            if (fin_a[k] == col_ff) begin
               f1_hit = 1'b1;
               f1_val = w1n[k];
            end
            if ({1'b0, fin_a[k]} == ra2) begin
               f2_hit = 1'b1;
               f2_val = w2n[k];
            end
         end
      end
   end

   edd_ram #(.DEPTH(MAX_WIDTH), .AW(CW)) u_next_ram (
      .clock   (clock),
      .wr_en   (mw_en),
      .wr_addr (mw_addr),
      .wr_data (mw_d1),
      .rd_en   (acc),
      .rd_addr (col_ff),
      .rd_data (m1_q)
   );

   edd_ram #(.DEPTH(MAX_WIDTH), .AW(CW)) u_after_ram (
      .clock   (clock),
      .wr_en   (mw_en),
      .wr_addr (mw_addr),
      .wr_data (mw_d2),
      .rd_en   (acc),
      .rd_addr (ra2[CW-1:0]),
      .rd_data (m2_q)
   );

   // ---------------- sequential ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         a0_ff   <= '0;
         a1_ff   <= '0;
         qcnt_ff <= '0;
      end else begin
         s1_v_ff <= acc;
         qcnt_ff <= nqcnt;
         if (s1_v_ff) begin
            a0_ff <= s1_rend_ff ? '0 : a0n;
            a1_ff <= s1_rend_ff ? '0 : a1n;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (acc) begin
         s1_pix_ff     <= req_tdata;
         s1_col_ff     <= col_ff;
         s1_row_ff     <= row_ff;
         s1_rend_ff    <= row_end_a;
         s1_fend_ff    <= frame_end_a;
         s1_cur_ok_ff  <= (row_ff != '0) && (col_ff <= last_col_ff);
         s1_seed_ok_ff <= (row_ff != '0) && (ra2 <= {1'b0, last_col_ff});
         s1_hv0_ff     <= (row_ff != '0);
         s1_hv1_ff     <= (row_ff != '0) && (last_col_ff != '0);
         s1_f1_hit_ff  <= f1_hit;
         s1_f1_val_ff  <= f1_val;
         s1_f2_hit_ff  <= f2_hit;
         s1_f2_val_ff  <= f2_val;
      end
      for (int i = 0; i < QD; i++) begin
         qa_ff[i] <= nqa[i];
         q1_ff[i] <= nq1[i];
         q2_ff[i] <= nq2[i];
      end
      if (s1_v_ff) begin
         for (int k = 0; k < 4; k++) begin
            w1_ff[k] <= w1n[k+1];
            w2_ff[k] <= w2n[k+1];
         end
      end
      for (int k = 0; k < 3; k++) begin
         if (fin_v[k] && (fin_a[k] < CW'(2))) begin
            head_ff[fin_a[k][0]] <= w2n[k];
         end
      end
   end

   // ---------------- output queue ----------------
   logic [8:0] oq_ff [OD];
   logic [1:0] owp_ff, orp_ff, ocnt_ff;
   logic       opop;

   assign opop       = rsp_tvalid && rsp_tready;
   assign rsp_tvalid = (ocnt_ff != 2'd0);
   assign rsp_tdata  = oq_ff[orp_ff][7:0];
   assign rsp_tlast  = oq_ff[orp_ff][8];
   assign req_tready = (3'(ocnt_ff) + 3'(s1_v_ff)) < 3'(OD);

   always_ff @(posedge clock) begin
      if (reset) begin
         owp_ff  <= '0;
         orp_ff  <= '0;
         ocnt_ff <= '0;
      end else begin
         if (s1_v_ff) begin
            owp_ff <= (owp_ff == 2'(OD - 1)) ? 2'd0 : owp_ff + 2'd1;
         end
         if (opop) begin
            orp_ff <= (orp_ff == 2'(OD - 1)) ? 2'd0 : orp_ff + 2'd1;
         end
         ocnt_ff <= ocnt_ff + 2'(s1_v_ff) - 2'(opop);
      end
   end

   always_ff @(posedge clock) begin
      if (s1_v_ff) begin
         oq_ff[owp_ff] <= {s1_fend_ff, qpx};
      end
   end

   // ---------------- checks ----------------
   `EDD_ASSERT(a_queue_bound, qcnt_ff <= QCW'(QD))
   `EDD_ASSERT(a_out_bound, 3'(ocnt_ff) + 3'(s1_v_ff) <= 3'(OD))
   `EDD_ASSERT_NEXT(a_row_end_clears, s1_v_ff && s1_rend_ff, a0_ff == '0 && a1_ff == '0)
   `EDD_ASSERT_NEXT(a_accept_to_s1, acc, s1_v_ff)

endmodule

// ===== design/edd_ram.sv =====
module edd_ram import edd_pkg::*; #(
   parameter int DEPTH = MAX_WIDTH_DEF,
   parameter int AW    = $clog2(MAX_WIDTH_DEF)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  acc_type       wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output acc_type       rd_data
);

   acc_type mem [DEPTH];
   acc_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== test/error_diffusion_dither_tb.sv =====
module error_diffusion_dither_tb;
   import edd_pkg::*;

   logic                 clock;
   logic                 reset;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [7:0]           req_tdata;   // [7:0] pixel_in
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   logic [7:0]           rsp_tdata;   // [7:0] pixel_out
   logic                 rsp_tlast;   // frame_end
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]     csr_wdata;

   error_diffusion_dither dut (.*);

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   // Kernel taps: row offset, column offset, weight; unused taps have weight 0.
   localparam int TAP_DR [4][12] = '{
      '{0, 1, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0},
      '{0, 0, 1, 1, 1, 1, 1, 2, 2, 2, 2, 2},
      '{0, 0, 1, 1, 1, 1, 1, 2, 2, 2, 0, 0},
      '{0, 0, 1, 1, 1, 2, 0, 0, 0, 0, 0, 0}};
   localparam int TAP_DC [4][12] = '{
      '{1, -1, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0},
      '{1, 2, -2, -1, 0, 1, 2, -2, -1, 0, 1, 2},
      '{1, 2, -2, -1, 0, 1, 2, -1, 0, 1, 0, 0},
      '{1, 2, -1, 0, 1, 0, 0, 0, 0, 0, 0, 0}};
   localparam int TAP_WT [4][12] = '{
      '{7, 3, 5, 1, 0, 0, 0, 0, 0, 0, 0, 0},
      '{7, 5, 3, 5, 7, 5, 3, 1, 3, 5, 3, 1},
      '{5, 3, 2, 4, 5, 4, 2, 2, 3, 2, 0, 0},
      '{1, 1, 1, 1, 1, 1, 0, 0, 0, 0, 0, 0}};
   localparam int KERN_DIV [4] = '{16, 48, 32, 8};
   localparam int RING_COLS = 4096;

   // Shadow of the block's registers and error state
   kern_type    sh_kernel;
   logic [3:0]  sh_bpp;
   logic [12:0] sh_width;
   logic [15:0] sh_height;
   int          col_pos, row_pos;
   int          err_ring [3][RING_COLS];
   int          ahead [2];

   typedef struct packed {
      logic [7:0] pixel;
      logic       frame_end;
   } dither_out_t;

   logic [7:0]  pixel_queue [$];
   dither_out_t expected_px [$];

   int  send_gap_max, recv_gap_max;
   int  send_gap, recv_gap;
   int  hold_cycles;
   int  hold_request;
   int  mismatches;
   int  cycles;

   function automatic int clamp_acc(int v);
      if (v > 511) return 511;
      if (v < -512) return -512;
      return v;
   endfunction

   function automatic void clear_errors();
      foreach (err_ring[r, c]) err_ring[r][c] = 0;
      ahead[0] = 0;
      ahead[1] = 0;
   endfunction

   // Dither one pixel against the shadow state, advance position.
   function automatic dither_out_t dither_pixel(logic [7:0] pix);
      dither_out_t res;
      int w, h, b, c, slot, sum, q, err, n0, n1, k, sh, tc, tr, t;
      w = (sh_width == 0) ? 1 : (sh_width > RING_COLS ? RING_COLS : int'(sh_width));
      h = (sh_height == 0) ? 1 : int'(sh_height);
      b = (sh_bpp == 0) ? 1 : (sh_bpp > 8 ? 8 : int'(sh_bpp));
      c = (col_pos >= RING_COLS) ? RING_COLS - 1 : col_pos;
      slot = row_pos % 3;
      k = int'(sh_kernel);
      sum = int'(pix) + err_ring[slot][c] + ahead[0];
      if (sum < 0) sum = 0;
      if (sum > 255) sum = 255;
      if (b >= 4) begin
         q = (sum >> (8 - b)) << (8 - b);
      end else if (b == 1) begin
         q = (sum >= 128) ? 255 : 0;
      end else if (b == 2) begin
         q = (sum >> 6) * 85;
      end else begin
         t = sum >> 5;
         q = t * 32 + t * 4 + t / 2;
      end
      err = sum - q;
      n0 = ahead[1];
      n1 = 0;
      for (int i = 0; i < 12; i++) begin
         if (TAP_WT[k][i] == 0) continue;
         sh = err * TAP_WT[k][i] / KERN_DIV[k];   // truncates toward zero
         tc = c + TAP_DC[k][i];
         if (tc < 0 || tc >= w) continue;
         if (TAP_DR[k][i] == 0) begin
            if (TAP_DC[k][i] == 1) n0 = clamp_acc(n0 + sh);
            else n1 = clamp_acc(n1 + sh);
         end else begin
            tr = row_pos + TAP_DR[k][i];
            if (tr >= h) continue;
            err_ring[tr % 3][tc] = clamp_acc(err_ring[tr % 3][tc] + sh);
         end
      end
      ahead[0] = n0;
      ahead[1] = n1;
      res.pixel = q[7:0];
      res.frame_end = 1'b0;
      if (c >= w - 1) begin
         ahead[0] = 0;
         ahead[1] = 0;
         col_pos = 0;
         if (row_pos >= h - 1) begin
            res.frame_end = 1'b1;
            clear_errors();
            row_pos = 0;
         end else begin
            for (int j = 0; j < RING_COLS; j++) err_ring[slot][j] = 0;
            row_pos = row_pos + 1;
         end
      end else begin
         col_pos = c + 1;
      end
      return res;
   endfunction

   // Sender: present the oldest pending pixel, random gap after each item.
   always @(posedge clock) begin
      logic nxt_valid;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         send_gap   = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_px.push_back(dither_pixel(req_tdata));
            void'(pixel_queue.pop_front());
            send_gap = $urandom_range(send_gap_max, 0);
         end
         nxt_valid = 1'b0;
         if (send_gap > 0) begin
            send_gap--;
         end else if (pixel_queue.size() > 0) begin
            nxt_valid = 1'b1;
            req_tdata <= pixel_queue[0];
         end
         req_tvalid <= nxt_valid;
      end
   end

   // Receiver: random stall per item, plus one long hold-off on request.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready  <= 1'b0;
         recv_gap    = 0;
         hold_cycles = 0;
      end else begin
         if (hold_request > 0 && hold_cycles == 0) hold_cycles = hold_request;
         if (rsp_tvalid && rsp_tready) recv_gap = $urandom_range(recv_gap_max, 0);
         if (hold_cycles > 1) begin
            hold_cycles--;
            rsp_tready <= 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Result checker
   always @(posedge clock) begin
      dither_out_t want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_px.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected item: pixel %0d last %0b", rsp_tdata, rsp_tlast);
         end else begin
            want = expected_px.pop_front();
            if (want.pixel !== rsp_tdata || want.frame_end !== rsp_tlast) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: pixel exp %0d got %0d, last exp %0b got %0b",
                           want.pixel, rsp_tdata, want.frame_end, rsp_tlast);
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > 400000) begin
         $display("status: fail");
         $finish;
      end
   end

   task automatic write_reg(csr_idx_type idx, logic [15:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         REG_KERNEL: sh_kernel = kern_type'(val[1:0]);
         REG_BPP:    sh_bpp    = val[3:0];
         REG_WIDTH:  sh_width  = val[12:0];
         REG_HEIGHT: sh_height = val;
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic drain();
      while (pixel_queue.size() > 0 || expected_px.size() > 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic setup(int kern, int bpp, int wid, int hgt);
      write_reg(REG_KERNEL, 16'(kern) | 16'($urandom_range(16'hFFFF, 0) & 16'hFFFC));
      write_reg(REG_BPP, 16'(bpp));
      write_reg(REG_WIDTH, 16'(wid));
      write_reg(REG_HEIGHT, 16'(hgt));
   endtask

   initial begin
      int wid, hgt, n, r;
      mismatches   = 0;
      cycles       = 0;
      hold_request = 0;
      send_gap_max = 0;
      recv_gap_max = 0;
      csr_we       = 1'b0;
      csr_index    = REG_KERNEL;
      csr_wdata    = '0;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      rsp_tready   = 1'b0;
      reset        = 1'b1;
      sh_kernel    = KERN_FS;
      sh_bpp       = 4'd1;
      sh_width     = 13'd640;
      sh_height    = 16'd480;
      col_pos      = 0;
      row_pos      = 0;
      clear_errors();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed: defaults, then eight pixels with extremes per kernel at a tiny 4x3 frame size
      pixel_queue = '{8'd0, 8'd255, 8'd128, 8'd127};
      drain();
      for (int k = 0; k < 4; k++) begin
         setup(k, (k == 0) ? 8 : (k == 1) ? 1 : (k == 2) ? 0 : 15, 4, 3);
         pixel_queue = '{8'd255, 8'd0, 8'd1, 8'd254, 8'd128, 8'd127, 8'd64, 8'd191};
         drain();
      end
      // Width zero, width past the maximum, height zero
      setup(KERN_JJN, 3, 0, 0);
      pixel_queue = '{8'd200, 8'd55, 8'd255};
      drain();
      setup(KERN_ATKINSON, 2, 8191, 65535);
      pixel_queue = '{8'd10, 8'd250, 8'd100};
      drain();

      // Random phases: registers change between phases, often mid-row
      for (int ph = 0; ph < 16; ph++) begin
         r = $urandom_range(9, 0);
         wid = (r == 0) ? 4096 : (r == 1) ? $urandom_range(8191, 0) : $urandom_range(12, 1);
         r = $urandom_range(9, 0);
         hgt = (r == 0) ? 65535 : (r == 1) ? 1 : $urandom_range(6, 0);
         setup($urandom_range(3, 0), $urandom_range(15, 0), wid, hgt);
         send_gap_max = (ph % 3 == 0) ? 0 : 11;
         recv_gap_max = (ph % 4 == 1) ? 0 : 11;
         if (ph == 5) begin
            // long receiver hold-off while the sender keeps offering
            send_gap_max = 0;
            @(posedge clock);
            hold_request <= 150;
            @(posedge clock);
            hold_request <= 0;
         end
         n = $urandom_range(40, 20);
         for (int i = 0; i < n; i++) begin
            r = $urandom_range(7, 0);
            pixel_queue.push_back((r == 0) ? 8'd0 : (r == 1) ? 8'd255 :
                                  8'($urandom_range(255, 0)));
         end
         drain();
      end

      repeat (10) @(posedge clock);
      if (mismatches == 0 && expected_px.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// ===== error_diffusion_dither.f =====
+incdir+design
design/edd_pkg.sv
design/edd_ram.sv
design/error_diffusion_dither.sv
test/error_diffusion_dither_tb.sv
